@@ sv/biq_pkg.sv @@
package biq_pkg;

  // Fixed widths of the datapath
  localparam int STATE_W   = 48;  // stored state, two's complement
  localparam int MRES_W    = 52;  // scaled product, always fits +-2^50
  localparam int ACC_W     = 54;  // accumulator, holds a sum of three products
  localparam int PC_W      = 5;
  localparam int CFG_IDX_W = 3;

  // Program entry points
  localparam logic [PC_W-1:0] PC_DF2 = 5'd0;
  localparam logic [PC_W-1:0] PC_TRN = 5'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0        = 3'd0,
    REG_COEF_B1        = 3'd1,
    REG_COEF_B2        = 3'd2,
    REG_COEF_A1        = 3'd3,
    REG_COEF_A2        = 3'd4,
    REG_STRUCTURE_MODE = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    BASE_ACC,
    BASE_ZERO,
    BASE_X,
    BASE_XFD2,
    BASE_FD1,
    BASE_WD1,
    BASE_WD2
  } base_sel_e;

  typedef enum logic [1:0] {
    MADD_NONE,
    MADD_ADD,
    MADD_SUB
  } madd_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_FD1,
    OPND_FD2,
    OPND_V,
    OPND_ACC
  } opnd_sel_e;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_EMIT
  } seq_op_e;

  typedef struct packed {
    logic wr_v;
    logic wr_fd1;
    logic wr_fd2;
    logic wr_wd1;
    logic wr_wd2;
    logic wr_y;
    logic shift_fd;  // fd2 <= fd1, fd1 <= v
  } store_t;

  typedef struct packed {
    base_sel_e base;
    madd_e     madd;
    coef_sel_e coef;
    opnd_sel_e opnd;
    store_t    st;
    seq_op_e   seq;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    base: BASE_ACC,
    madd: MADD_NONE,
    coef: COEF_B0,
    opnd: OPND_FD1,
    st:   '0,
    seq:  SEQ_NEXT
  };

  // Control store. A product reaches mres through the pp and mres registers.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (pc)
      // direct form II
      5'd0: begin
        c.base = BASE_X;   c.coef = COEF_A1; c.opnd = OPND_FD1;
      end
      5'd1: begin
        c.coef = COEF_A2;  c.opnd = OPND_FD2;
      end
      5'd2: begin
        c.madd = MADD_SUB; c.coef = COEF_B1; c.opnd = OPND_FD1;
      end
      5'd3: begin
        c.madd = MADD_SUB; c.coef = COEF_B2; c.opnd = OPND_FD2;
      end
      5'd4: begin
        c.base = BASE_ZERO; c.madd = MADD_ADD;
        c.coef = COEF_B0;   c.opnd = OPND_ACC; c.st.wr_v = 1'b1;
      end
      5'd5: c.madd = MADD_ADD;
      5'd6: c.madd = MADD_ADD;
      5'd7: begin
        c.st.wr_y = 1'b1; c.st.shift_fd = 1'b1;
      end
      5'd8: c.seq = SEQ_EMIT;
      // transposed form
      5'd9:  c.base = BASE_XFD2;
      5'd10: begin
        c.coef = COEF_B0; c.opnd = OPND_ACC; c.st.wr_v = 1'b1;
      end
      5'd11: begin
        c.coef = COEF_B1; c.opnd = OPND_V;
      end
      5'd12: begin
        c.base = BASE_WD2; c.madd = MADD_ADD; c.coef = COEF_B2; c.opnd = OPND_V;
      end
      5'd13: begin
        c.base = BASE_WD1; c.madd = MADD_ADD; c.coef = COEF_A1; c.opnd = OPND_V;
        c.st.wr_y = 1'b1;
      end
      5'd14: begin
        c.base = BASE_ZERO; c.madd = MADD_ADD; c.coef = COEF_A2; c.opnd = OPND_V;
        c.st.wr_wd2 = 1'b1;
      end
      5'd15: begin
        c.base = BASE_FD1; c.madd = MADD_SUB; c.st.wr_wd1 = 1'b1;
      end
      5'd16: begin
        c.base = BASE_ZERO; c.madd = MADD_SUB; c.st.wr_fd2 = 1'b1;
      end
      5'd17: begin
        c.st.wr_fd1 = 1'b1; c.seq = SEQ_EMIT;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

@@ sv/biq_if.sv @@
interface biq_in_if #(parameter int WIDTH = 24);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(parameter int WIDTH = 24);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface biq_cfg_if #(parameter int DATA_W = 32);
  logic                            valid;
  logic                            ready;
  logic [biq_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_W-1:0]               value;
  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

@@ sv/biq_mul.sv @@
module biq_mul #(
  parameter int COEF_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic signed [COEF_WIDTH-1:0]            coef_i,
  input  logic signed [biq_pkg::STATE_W-1:0]      opnd_i,
  output logic signed [biq_pkg::MRES_W-1:0]       mres_o
);
  import biq_pkg::*;

  localparam int LO_W   = 16;
  localparam int HI_W   = STATE_W - LO_W;
  localparam int PH_W   = COEF_WIDTH + HI_W;
  localparam int PL_W   = COEF_WIDTH + LO_W + 1;
  localparam int FULL_W = COEF_WIDTH + STATE_W;
  localparam int FRAC   = COEF_WIDTH - 4;

  logic signed [HI_W-1:0]   op_hi;
  logic signed [LO_W:0]     op_lo;
  logic signed [PH_W-1:0]   pp_hi_d, pp_hi_q;
  logic signed [PL_W-1:0]   pp_lo_d, pp_lo_q;
  logic signed [FULL_W-1:0] full;
  logic signed [MRES_W-1:0] mres_d, mres_q;

  // signed upper part, unsigned lower part
  assign op_hi   = opnd_i[STATE_W-1:LO_W];
  assign op_lo   = {1'b0, opnd_i[LO_W-1:0]};
  assign pp_hi_d = PH_W'(coef_i) * PH_W'(op_hi);
  assign pp_lo_d = PL_W'(coef_i) * PL_W'(op_lo);

  // exact product, floor by arithmetic shift
  assign full   = (FULL_W'(pp_hi_q) <<< LO_W) + FULL_W'(pp_lo_q);
  assign mres_d = full[FULL_W-1:FRAC];

  always_ff @(posedge clk_i) begin
    pp_hi_q <= pp_hi_d;
    pp_lo_q <= pp_lo_d;
    mres_q  <= mres_d;
  end

  assign mres_o = mres_q;

endmodule

@@ sv/biq_dp.sv @@
module biq_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  biq_pkg::ctrl_t                       ctrl_i,
  input  logic                                 cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COEF_WIDTH-1:0]                cfg_value_i,
  input  logic                                 in_load_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic signed [biq_pkg::MRES_W-1:0]    mres_i,
  output logic signed [COEF_WIDTH-1:0]         mul_coef_o,
  output logic signed [biq_pkg::STATE_W-1:0]   mul_opnd_o,
  output logic                                 mode_o,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_o
);
  import biq_pkg::*;

  localparam int STATE_FRAC = 40 - SAMPLE_WIDTH;
  localparam int RND_W      = ACC_W + 1;
  localparam logic signed [RND_W-1:0] RND_C = RND_W'(1) <<< (STATE_FRAC - 1);
  localparam logic [COEF_WIDTH-1:0]   B0_RST = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-STATE_W:0] hi_bits;
    hi_bits = a[ACC_W-1:STATE_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return a[STATE_W-1:0];
    end
    return a[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic                           mode_q;
  logic signed [STATE_W-1:0]      fd1_q, fd2_q, wd1_q, wd2_q;
  logic signed [STATE_W-1:0]      v_q;
  logic signed [ACC_W-1:0]        acc_q, acc_d, y_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [ACC_W-1:0]        x_ext, base, mres_ext;
  logic signed [STATE_W-1:0]      acc_sat;
  logic signed [RND_W-1:0]        rnd_sum, rnd;
  logic [RND_W-SAMPLE_WIDTH:0]    rnd_hi;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= B0_RST;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_COEF_B0)        b0_q   <= cfg_value_i;
      if (cfg_index_i == REG_COEF_B1)        b1_q   <= cfg_value_i;
      if (cfg_index_i == REG_COEF_B2)        b2_q   <= cfg_value_i;
      if (cfg_index_i == REG_COEF_A1)        a1_q   <= cfg_value_i;
      if (cfg_index_i == REG_COEF_A2)        a2_q   <= cfg_value_i;
      if (cfg_index_i == REG_STRUCTURE_MODE) mode_q <= cfg_value_i[0];
    end
  end

  assign mode_o = mode_q;

  assign x_ext    = ACC_W'(x_q) <<< STATE_FRAC;
  assign mres_ext = ACC_W'(mres_i);
  assign acc_sat  = sat_state(acc_q);

  always_comb begin
    unique case (ctrl_i.coef)
      COEF_B0: mul_coef_o = b0_q;
      COEF_B1: mul_coef_o = b1_q;
      COEF_B2: mul_coef_o = b2_q;
      COEF_A1: mul_coef_o = a1_q;
      COEF_A2: mul_coef_o = a2_q;
      default: mul_coef_o = b0_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.opnd)
      OPND_FD1: mul_opnd_o = fd1_q;
      OPND_FD2: mul_opnd_o = fd2_q;
      OPND_V:   mul_opnd_o = v_q;
      OPND_ACC: mul_opnd_o = acc_sat;
      default:  mul_opnd_o = fd1_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.base)
      BASE_ACC:  base = acc_q;
      BASE_ZERO: base = '0;
      BASE_X:    base = x_ext;
      BASE_XFD2: base = x_ext + ACC_W'(fd2_q);
      BASE_FD1:  base = ACC_W'(fd1_q);
      BASE_WD1:  base = ACC_W'(wd1_q);
      BASE_WD2:  base = ACC_W'(wd2_q);
      default:   base = acc_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.madd)
      MADD_NONE: acc_d = base;
      MADD_ADD:  acc_d = base + mres_ext;
      MADD_SUB:  acc_d = base - mres_ext;
      default:   acc_d = base;
    endcase
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd1_q <= '0;
      fd2_q <= '0;
      wd1_q <= '0;
      wd2_q <= '0;
    end else begin
      if (ctrl_i.st.shift_fd) begin
        fd2_q <= fd1_q;
        fd1_q <= v_q;
      end
      if (ctrl_i.st.wr_fd1) fd1_q <= acc_sat;
      if (ctrl_i.st.wr_fd2) fd2_q <= acc_sat;
      if (ctrl_i.st.wr_wd1) wd1_q <= acc_sat;
      if (ctrl_i.st.wr_wd2) wd2_q <= acc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_load_i)      x_q <= sample_i;
    if (ctrl_i.st.wr_v) v_q <= acc_sat;
    if (ctrl_i.st.wr_y) y_q <= acc_q;
  end

  // round half up, then clamp to the sample range
  assign rnd_sum = RND_W'(y_q) + RND_C;
  assign rnd     = rnd_sum >>> STATE_FRAC;
  assign rnd_hi  = rnd[RND_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&rnd_hi) || !(|rnd_hi)) begin
      sample_o = rnd[SAMPLE_WIDTH-1:0];
    end else if (rnd[RND_W-1]) begin
      sample_o = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

endmodule

@@ sv/biq_seq.sv @@
module biq_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           mode_i,
  input  logic           out_blocked_i,
  output biq_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           emit_o
);
  import biq_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;
  ctrl_t           word;

  assign word   = ucode(pc_q);
  assign ctrl_o = busy_q ? word : CTRL_NOP;
  assign emit_o = busy_q && (word.seq == SEQ_EMIT) && !out_blocked_i;
  assign busy_o = busy_q;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = mode_i ? PC_TRN : PC_DF2;
      end
    end else begin
      unique case (word.seq)
        SEQ_NEXT: pc_d = pc_q + PC_W'(1);
        SEQ_EMIT: begin
          // hold on the last word until the output slot frees
          if (!out_blocked_i) busy_d = 1'b0;
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_DF2;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

@@ sv/biquad_iir_filter.sv @@
// Channel | Dir | Payload                    | Transfer when
// --------+-----+----------------------------+-----------------------
// in_i    | in  | sample_in  (signed)        | in_i.valid & in_i.ready
// out_o   | out | sample_out (signed)        | out_o.valid & out_o.ready
// cfg_i   | in  | index, value (coef / mode) | cfg_i.valid & cfg_i.ready
//
// One sample is in flight at a time; its input slot frees once it is done:
// a 9-word microprogram drives one shared 32x48 multiplier, whose pp and mres
// registers hold its product. The result waits in an output register;
// a stalled output holds the program on its last word. cfg_i is always ready.
// rst_ni is asynchronous, active low; coefficients reset to b0 = 1.0, rest 0.
module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  biq_in_if.sink   in_i,
  biq_out_if.source out_o,
  biq_cfg_if.sink  cfg_i
);
  import biq_pkg::*;

  ctrl_t                          ctrl;
  logic                           busy;
  logic                           emit;
  logic                           in_xfer;
  logic                           out_blocked;
  logic                           mode;
  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [STATE_W-1:0]      mul_opnd;
  logic signed [MRES_W-1:0]       mres;
  logic signed [SAMPLE_WIDTH-1:0] result;

  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

  // one sample in flight; the next is taken once the result is parked
  assign in_i.ready  = !busy;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_blocked = out_valid_q && !out_o.ready;

  biq_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_xfer),
    .mode_i        (mode),
    .out_blocked_i (out_blocked),
    .ctrl_o        (ctrl),
    .busy_o        (busy),
    .emit_o        (emit)
  );

  biq_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_value_i (cfg_i.value),
    .in_load_i   (in_xfer),
    .sample_i    (in_i.sample_in),
    .mres_i      (mres),
    .mul_coef_o  (mul_coef),
    .mul_opnd_o  (mul_opnd),
    .mode_o      (mode),
    .sample_o    (result)
  );

  biq_mul #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .coef_i (mul_coef),
    .opnd_i (mul_opnd),
    .mres_o (mres)
  );

  // output register: set by the program's last word, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (emit)                       out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) sample_out_q <= result;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;

endmodule
